/* rtl/aeg_pkg.sv */
// ----------------------------------------------------------------------------
// aeg_pkg
// Shared types and constants of the linear ADSR envelope generator.
// ----------------------------------------------------------------------------
package aeg_pkg;

  localparam int TIME_BITS = 24;
  localparam int FRAC_BITS = 15;
  localparam int LEVEL_W   = 16;
  localparam int TICK_W    = 20;
  localparam int SAMPLE_W  = 16;
  localparam int OP_W      = 2;
  localparam int STAGE_W   = 3;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = LEVEL_W + SAMPLE_W + 1;

  localparam int MUL_STEPS = TICK_W;
  localparam int DIV_STEPS = LEVEL_W;
  localparam int CNT_W     = $clog2(MUL_STEPS);

  localparam logic [LEVEL_W-1:0]   ONE_LEVEL   = LEVEL_W'(1 << FRAC_BITS);
  localparam logic [TIME_BITS-1:0] TIME_MAX    = {TIME_BITS{1'b1}};
  localparam logic [TICK_W-1:0]    ATTACK_RST  = TICK_W'(0);
  localparam logic [TICK_W-1:0]    DECAY_RST   = TICK_W'(0);
  localparam logic [LEVEL_W-1:0]   SUSTAIN_RST = LEVEL_W'(32768);
  localparam logic [TICK_W-1:0]    RELEASE_RST = TICK_W'(44100);

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_BEGIN = 2'd1,
    OP_END   = 2'd2
  } op_t;

  typedef enum logic [STAGE_W-1:0] {
    ST_INACTIVE = 3'd0,
    ST_ATTACK   = 3'd1,
    ST_DECAY    = 3'd2,
    ST_SUSTAIN  = 3'd3,
    ST_RELEASE  = 3'd4
  } stage_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK  = 2'd0,
    CFG_DECAY   = 2'd1,
    CFG_SUSTAIN = 2'd2,
    CFG_RELEASE = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POS,
    S_SETUP,
    S_DIV,
    S_SCALE,
    S_PUSH
  } eg_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_t;

  typedef struct packed {
    logic               start;
    logic [LEVEL_W-1:0] mult;
    logic [TICK_W-1:0]  num;
    logic [TICK_W-1:0]  den;
  } md_req_t;

endpackage

/* rtl/aeg_muldiv.sv */
// ----------------------------------------------------------------------------
// aeg_muldiv
// Bit-serial floor(mult * num / den): shift-add multiply, then restoring divide.
// ----------------------------------------------------------------------------
module aeg_muldiv import aeg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  md_req_t            req,
  output logic               done,
  output logic [LEVEL_W-1:0] quo
);

  md_state_t state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [LEVEL_W-1:0] mult_r;
  logic [LEVEL_W-1:0] hi_r;
  logic [TICK_W-1:0]  lo_r;
  logic [TICK_W-1:0]  den_r;
  logic [TICK_W-1:0]  rem_r;
  logic [LEVEL_W-1:0] quo_r;
  logic               done_r;

  logic               mul_step;
  logic               div_step;
  logic               mul_last;
  logic               div_last;
  logic [LEVEL_W:0]   sum;
  logic [LEVEL_W-1:0] hi_nxt;
  logic [TICK_W-1:0]  lo_nxt;
  logic [TICK_W:0]    trial;
  logic [TICK_W:0]    diff;
  logic               ge;

  assign mul_last = (cnt_r == CNT_W'(MUL_STEPS - 1));
  assign div_last = (cnt_r == CNT_W'(DIV_STEPS - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      MD_IDLE: if (req.start) state_nxt = MD_MUL;
      MD_MUL:  if (mul_last) state_nxt = MD_DIV;
      MD_DIV:  if (div_last) state_nxt = MD_IDLE;
      default: state_nxt = MD_IDLE;
    endcase
  end

  always_comb begin
    mul_step = 1'b0;
    div_step = 1'b0;
    unique case (state_r)
      MD_MUL:  mul_step = 1'b1;
      MD_DIV:  div_step = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    sum    = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mult_r} : '0);
    hi_nxt = sum[LEVEL_W:1];
    lo_nxt = {sum[0], lo_r[TICK_W-1:1]};
    trial  = {rem_r, quo_r[LEVEL_W-1]};
    diff   = trial - {1'b0, den_r};
    ge     = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= div_step && div_last;
      if (state_r == MD_IDLE && req.start) begin
        mult_r <= req.mult;
        hi_r   <= '0;
        lo_r   <= req.num;
        den_r  <= req.den;
        cnt_r  <= '0;
      end
      if (mul_step) begin
        hi_r  <= hi_nxt;
        lo_r  <= lo_nxt;
        cnt_r <= mul_last ? '0 : cnt_r + 1'b1;
        if (mul_last) begin
          rem_r <= {hi_nxt, lo_nxt[TICK_W-1:LEVEL_W]};
          quo_r <= lo_nxt[LEVEL_W-1:0];
        end
      end
      if (div_step) begin
        rem_r <= ge ? diff[TICK_W-1:0] : trial[TICK_W-1:0];
        quo_r <= {quo_r[LEVEL_W-2:0], ge};
        cnt_r <= div_last ? '0 : cnt_r + 1'b1;
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

/* rtl/adsr_envelope_generator.sv */
// ----------------------------------------------------------------------------
// adsr_envelope_generator
// Linear ADSR envelope: stage machine, ramp setup and output scaling.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       input      in_valid/in_ready    in_operation, in_sample_in
//  out      output     out_valid/out_ready  out_sample_out, out_amplitude, out_stage
//  cfg      input      cfg_wr_en            cfg_index, cfg_wr_data
//
//  After acceptance, a tick registers its ramp position, sets up the ramp,
//  waits for the 20 multiply and 16 divide steps (one bit each) when a ramp
//  is computed, then scales the sample and pushes the result.
//  Begin and end transactions give no result.
//  A new transaction is taken only in idle; a finished result waits in the
//  output register, and the next tick stalls at its end until it drains.
//  rst_n is synchronous; configuration registers reset to their defaults.
// ----------------------------------------------------------------------------
module adsr_envelope_generator import aeg_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [OP_W-1:0]            in_operation,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  output logic [LEVEL_W-1:0]         out_amplitude,
  output logic [STAGE_W-1:0]         out_stage,
  input  logic                       cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [TICK_W-1:0]          cfg_wr_data
);

  eg_state_t state_r, state_nxt;

  logic [TICK_W-1:0]    attack_r;
  logic [TICK_W-1:0]    decay_r;
  logic [LEVEL_W-1:0]   sustain_r;
  logic [TICK_W-1:0]    release_r;

  stage_t               stage_r;
  logic [TIME_BITS-1:0] elapsed_r;
  logic [LEVEL_W-1:0]   level_r;
  logic [TIME_BITS-1:0] rel_start_r;
  logic [LEVEL_W-1:0]   rel_level_r;

  logic signed [SAMPLE_W-1:0] sample_r;
  logic [TICK_W-1:0]          pos_r;
  logic                       over_r;
  logic [LEVEL_W-1:0]         offset_r;
  logic signed [PROD_W-1:0]   prod_r;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic [LEVEL_W-1:0]         out_level_r;
  logic [STAGE_W-1:0]         out_stage_r;

  logic                 in_fire;
  logic                 push;
  logic [TIME_BITS-1:0] start_sel;
  logic [TICK_W-1:0]    len_sel;
  logic [TIME_BITS-1:0] delta;
  logic                 over;
  logic [TICK_W-1:0]    pos;
  logic [LEVEL_W-1:0]   sus;
  logic                 ramp_stage;
  logic                 len_zero;
  md_req_t              md_req;
  logic                 md_done;
  logic [LEVEL_W-1:0]   md_quo;

  assign in_fire = in_valid && in_ready;
  assign push    = !out_valid_r || out_ready;

  always_comb begin
    start_sel  = '0;
    len_sel    = '0;
    ramp_stage = 1'b0;
    unique case (stage_r)
      ST_ATTACK: begin
        len_sel    = attack_r;
        ramp_stage = 1'b1;
      end
      ST_DECAY: begin
        start_sel  = TIME_BITS'(attack_r);
        len_sel    = decay_r;
        ramp_stage = 1'b1;
      end
      ST_RELEASE: begin
        start_sel  = rel_start_r;
        len_sel    = release_r;
        ramp_stage = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    delta    = (elapsed_r > start_sel) ? elapsed_r - start_sel : '0;
    over     = (delta > TIME_BITS'(len_sel));
    pos      = over ? len_sel : delta[TICK_W-1:0];
    sus      = (sustain_r > ONE_LEVEL) ? ONE_LEVEL : sustain_r;
    len_zero = (len_sel == '0);
  end

  always_comb begin
    md_req.start = 1'b0;
    md_req.mult  = ONE_LEVEL;
    md_req.num   = pos_r;
    md_req.den   = len_sel;
    unique case (stage_r)
      ST_DECAY: begin
        md_req.mult = ONE_LEVEL - sus;
        md_req.num  = decay_r - pos_r;
      end
      ST_RELEASE: begin
        md_req.mult = rel_level_r;
        md_req.num  = release_r - pos_r;
      end
      default: ;
    endcase
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE:  in_ready = 1'b1;
      S_SETUP: md_req.start = ramp_stage && !len_zero;
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire && op_t'(in_operation) == OP_TICK) state_nxt = S_POS;
      S_POS:   state_nxt = S_SETUP;
      S_SETUP: state_nxt = md_req.start ? S_DIV : S_SCALE;
      S_DIV:   if (md_done) state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_PUSH;
      S_PUSH:  if (push) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  aeg_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .done  (md_done),
    .quo   (md_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      attack_r    <= ATTACK_RST;
      decay_r     <= DECAY_RST;
      sustain_r   <= SUSTAIN_RST;
      release_r   <= RELEASE_RST;
      stage_r     <= ST_INACTIVE;
      elapsed_r   <= '0;
      level_r     <= '0;
      rel_start_r <= '0;
      rel_level_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_ATTACK:  attack_r  <= cfg_wr_data;
          CFG_DECAY:   decay_r   <= cfg_wr_data;
          CFG_SUSTAIN: sustain_r <= cfg_wr_data[LEVEL_W-1:0];
          CFG_RELEASE: release_r <= cfg_wr_data;
          default: ;
        endcase
      end
      if (state_r == S_PUSH && push) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            unique case (op_t'(in_operation))
              OP_TICK: begin
                elapsed_r <= (elapsed_r == TIME_MAX) ? elapsed_r : elapsed_r + 1'b1;
                sample_r  <= in_sample_in;
              end
              OP_BEGIN: begin
                elapsed_r   <= '0;
                rel_start_r <= '0;
                stage_r     <= ST_ATTACK;
              end
              OP_END: begin
                rel_start_r <= elapsed_r;
                rel_level_r <= level_r;
                stage_r     <= ST_RELEASE;
              end
              default: ;
            endcase
          end
        end
        S_POS: begin
          pos_r  <= pos;
          over_r <= over;
        end
        S_SETUP: begin
          offset_r <= (stage_r == ST_DECAY) ? sus : '0;
          unique case (stage_r)
            ST_ATTACK: begin
              if (over_r) stage_r <= ST_DECAY;
              if (len_zero) level_r <= ONE_LEVEL;
            end
            ST_DECAY: begin
              if (over_r) stage_r <= ST_SUSTAIN;
              if (len_zero) level_r <= sus;
            end
            ST_SUSTAIN: begin
              rel_start_r <= elapsed_r;
              rel_level_r <= level_r;
              stage_r     <= ST_RELEASE;
            end
            ST_RELEASE: begin
              if (len_zero) level_r <= '0;
            end
            default: ;
          endcase
        end
        S_DIV: begin
          if (md_done) level_r <= offset_r + md_quo;
        end
        S_SCALE: begin
          prod_r <= $signed({1'b0, level_r}) * sample_r;
        end
        S_PUSH: begin
          if (push) begin
            out_sample_r <= prod_r[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
            out_level_r  <= level_r;
            out_stage_r  <= stage_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_amplitude  = out_level_r;
  assign out_stage      = out_stage_r;

`ifndef ASSERT_OFF
  a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= ONE_LEVEL)
    else $error("envelope level above one");

  a_rel_level_max: assert property (@(posedge clk) disable iff (!rst_n)
    rel_level_r <= ONE_LEVEL)
    else $error("release level above one");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    md_done |-> state_r == S_DIV)
    else $error("ramp unit done outside divide wait");

  a_push_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH && out_valid_r && !out_ready) |=> state_r == S_PUSH)
    else $error("result overwrote a pending transaction");
`endif

endmodule
